[design/brm_pkg.sv]
// brm_pkg: shared types and constants for the bytecode register machine
// no dependencies; used by brm_step and bytecode_register_machine_top
package brm_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int NUM_REGS   = 4;
    localparam int KEY_W      = 32;
    localparam int ACC_W      = 32;
    localparam int RESULT_W   = 32;

    // opcode byte layout: bit 0 selects register source, bits 5:4 the operation
    localparam logic [7:0] OPC_KNOWN_MASK = 8'hCE;

    localparam logic [2:0] POS_OPCODE   = 3'd0;
    localparam logic [2:0] POS_DEST     = 3'd1;
    localparam logic [2:0] POS_OPERAND  = 3'd2;
    localparam logic [2:0] POS_LAST_IMM = 3'd5;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [1:0] {
        ALU_MOV = 2'd0,
        ALU_ADD = 2'd1,
        ALU_SUB = 2'd2,
        ALU_XOR = 2'd3
    } t_alu_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_OP  = 2'd1,
        ST_PARTIAL = 2'd2
    } t_status;

    typedef struct packed {
        logic [NUM_REGS-1:0][DATA_WIDTH-1:0] regs;
        logic [2:0]                          pos;
        logic [7:0]                          opcode;
        logic [7:0]                          dest;
        logic [ACC_W-1:0]                    acc;
        logic                                err;
    } t_mach_state;

    typedef struct packed {
        logic                kind;
        logic [KEY_W-1:0]    key_value;
        logic [7:0]          code_byte;
        logic                last_byte;
    } t_item;

endpackage

[design/brm_step.sv]
// brm_step: next-state logic for one word (start or program byte)
// depends on brm_pkg
module brm_step (
    input  brm_pkg::t_mach_state i_cur,
    input  brm_pkg::t_item       i_item,
    output brm_pkg::t_mach_state o_nxt,
    output logic                 o_emit,
    output brm_pkg::t_status     o_status
);

    brm_pkg::t_mach_state        s;
    logic                        do_exec;
    logic [brm_pkg::DATA_WIDTH-1:0] src;
    logic [brm_pkg::DATA_WIDTH-1:0] dst;
    logic                        src_ok;
    logic [1:0]                  imm_lane;
    logic [brm_pkg::ACC_W-1:0]   new_acc;

    always_comb begin
        s        = i_cur;
        do_exec  = 1'b0;
        new_acc  = i_cur.acc;
        imm_lane = 2'(i_cur.pos - brm_pkg::POS_OPERAND);
        src      = '0;
        src_ok   = 1'b0;
        dst      = '0;
        o_emit   = 1'b0;
        o_status = brm_pkg::ST_OK;

        if (i_item.kind == brm_pkg::KIND_START) begin
            s.regs[0] = brm_pkg::DATA_WIDTH'(i_item.key_value);
            for (int i = 1; i < brm_pkg::NUM_REGS; i++) begin
                s.regs[i] = '0;
            end
            s.pos = brm_pkg::POS_OPCODE;
            s.err = 1'b0;
            s.acc = '0;
        end else begin
            case (i_cur.pos)
                brm_pkg::POS_OPCODE: begin
                    if ((i_item.code_byte & brm_pkg::OPC_KNOWN_MASK) == 8'h00) begin
                        s.opcode = i_item.code_byte;
                        s.pos    = brm_pkg::POS_DEST;
                    end else begin
                        s.err = 1'b1;
                    end
                end
                brm_pkg::POS_DEST: begin
                    s.dest = i_item.code_byte;
                    s.acc  = '0;
                    s.pos  = brm_pkg::POS_OPERAND;
                end
                default: begin
                    if (i_cur.opcode[0]) begin
                        new_acc = brm_pkg::ACC_W'(i_item.code_byte);
                        do_exec = 1'b1;
                        s.pos   = brm_pkg::POS_OPCODE;
                    end else begin
                        // little-endian immediate, one byte lane per position
                        new_acc = i_cur.acc
                                | (brm_pkg::ACC_W'(i_item.code_byte) << {imm_lane, 3'b000});
                        if (i_cur.pos >= brm_pkg::POS_LAST_IMM) begin
                            do_exec = 1'b1;
                            s.pos   = brm_pkg::POS_OPCODE;
                        end else begin
                            s.pos = i_cur.pos + 3'd1;
                        end
                    end
                    s.acc = new_acc;
                end
            endcase

            if (i_cur.opcode[0]) begin
                src_ok = (new_acc < brm_pkg::ACC_W'(brm_pkg::NUM_REGS));
                src    = i_cur.regs[new_acc[1:0]];
            end else begin
                src_ok = 1'b1;
                src    = brm_pkg::DATA_WIDTH'(new_acc);
            end

            // out-of-range register index leaves the registers unchanged
            if (do_exec && src_ok && (i_cur.dest < 8'(brm_pkg::NUM_REGS))) begin
                dst = i_cur.regs[i_cur.dest[1:0]];
                case (brm_pkg::t_alu_op'(i_cur.opcode[5:4]))
                    brm_pkg::ALU_MOV: dst = src;
                    brm_pkg::ALU_ADD: dst = dst + src;
                    brm_pkg::ALU_SUB: dst = dst - src;
                    brm_pkg::ALU_XOR: dst = dst ^ src;
                    default:          dst = src;
                endcase
                s.regs[i_cur.dest[1:0]] = dst;
            end
        end

        if (i_item.last_byte) begin
            o_emit = 1'b1;
            if (s.pos != brm_pkg::POS_OPCODE) begin
                o_status = brm_pkg::ST_PARTIAL;
            end else if (s.err) begin
                o_status = brm_pkg::ST_BAD_OP;
            end else begin
                o_status = brm_pkg::ST_OK;
            end
            s.pos = brm_pkg::POS_OPCODE;
            s.err = 1'b0;
        end

        o_nxt = s;
    end

endmodule

[design/bytecode_register_machine_top.sv]
// bytecode_register_machine_top: input register, machine state, result register
// depends on brm_pkg and brm_step
// timing: an accepted word is held in the input register; its result is registered on advance
// throughput: one word per cycle; the state update through brm_step
//   sets this figure, and a full unread result register stalls only a last word
// reset: synchronous active-low i_rst_n clears the machine registers, instruction state
//   and both valid flags
module bytecode_register_machine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_key_value,
    input  logic [7:0]  i_code_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_status
);

    logic                  r_in_vld;
    brm_pkg::t_item        r_item;
    brm_pkg::t_mach_state  r_st;
    brm_pkg::t_mach_state  n_st;
    logic                  r_out_vld;
    logic [brm_pkg::RESULT_W-1:0] r_result;
    brm_pkg::t_status      r_status;

    logic                  w_emit;
    brm_pkg::t_status      w_status;
    logic                  w_adv;

    brm_step u_step (
        .i_cur    (r_st),
        .i_item   (r_item),
        .o_nxt    (n_st),
        .o_emit   (w_emit),
        .o_status (w_status)
    );

    // only a word that produces a result has to wait for the output register
    assign w_adv      = r_in_vld && (!w_emit || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.kind      <= i_kind;
            r_item.key_value <= i_key_value;
            r_item.code_byte <= i_code_byte;
            r_item.last_byte <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_result <= brm_pkg::RESULT_W'(n_st.regs[0]);
            r_status <= w_status;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_result;
    assign o_status       = r_status;

endmodule
